/* design/hall_pulse_rpm_meter_assert.svh */
// assertion macros for the rpm meter checker
`ifndef HALL_PULSE_RPM_METER_ASSERT_SVH
`define HALL_PULSE_RPM_METER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define HPRM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hall_pulse_rpm_meter: same-cycle check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define HPRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hall_pulse_rpm_meter: next-cycle check failed");

`endif

/* design/hprm_pkg.sv */
// shared types and constants of the hall pulse rpm meter
`default_nettype none

package hprm_pkg;

    // input event codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_PULSE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_DIR   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MIN_WINDOW = 2'd0;
    localparam logic [1:0] CFG_CPR        = 2'd1;
    localparam logic [1:0] CFG_GEAR       = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd3;

    localparam int CFG_W = 16;

    // configuration reset values
    localparam logic [CFG_W-1:0] MIN_WINDOW_RST = 16'd100;
    localparam logic [CFG_W-1:0] CPR_RST        = 16'd11;
    localparam logic [CFG_W-1:0] GEAR_RST       = 16'd7680;
    localparam logic [CFG_W-1:0] TIMEOUT_RST    = 16'd500;

    // microseconds per millisecond
    localparam logic [31:0] US_PER_MS = 32'd1000;

    // 60e6 * 256 split into a 2-bit high part and a 32-bit low part: 3 * 2^32 + lo
    localparam logic [31:0] SCALE_LO = 32'd2475098112;
    localparam logic [1:0]  SCALE_HI = 2'd3;
    localparam int          SCALE_W  = 34;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic mul1;
        logic mul2;
        logic prep;
        logic div_step;
        logic finish;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic win_done;
    } t_dp_sts;

endpackage

`default_nettype wire

/* design/hprm_dp.sv */
// datapath: counters, configuration, rpm products and shift-subtract divider
`default_nettype none

module hprm_dp import hprm_pkg::*; #(
    parameter int COUNT_BITS = 24,
    parameter int RPM_BITS   = 14
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_dp_cmd                    i_cmd,
    output t_dp_sts                         o_sts,
    input  wire logic [1:0]                 i_opcode,
    input  wire logic                       i_forward,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [CFG_W-1:0]           i_cfg_data,
    output logic signed [RPM_BITS-1:0]      o_rpm,
    output logic                            o_stale,
    output logic                            o_updated
);

    localparam int K     = RPM_BITS - 1;
    localparam int N_W   = COUNT_BITS + SCALE_W;
    localparam int X_W   = ((N_W + 1 > 64) ? N_W + 1 : 64) + 1;
    localparam int D_W   = 65;
    localparam int WIDE  = (X_W > D_W + K) ? X_W : D_W + K;
    localparam logic [RPM_BITS-1:0] RPM_MAX = {1'b0, {K{1'b1}}};

    logic [CFG_W-1:0]      r_min_window, r_cpr, r_gear, r_timeout;
    logic [COUNT_BITS-1:0] r_count;
    logic [31:0]           r_elapsed, r_since;
    logic [RPM_BITS-1:0]   r_held;
    logic                  r_dir, r_updated;
    logic [47:0]           r_p1;
    logic [N_W-1:0]        r_num;
    logic                  r_czero;
    logic [63:0]           r_den;
    logic [WIDE-1:0]       r_rem, r_dsh;
    logic [K:0]            r_q;

    logic                  n_qbit;
    logic [RPM_BITS-1:0]   n_mag;

    // window threshold in microseconds
    assign o_sts.win_done = r_elapsed >= (32'(r_min_window) * US_PER_MS);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_window <= MIN_WINDOW_RST;
            r_cpr        <= CPR_RST;
            r_gear       <= GEAR_RST;
            r_timeout    <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_WINDOW: r_min_window <= i_cfg_data;
                CFG_CPR:        r_cpr        <= i_cfg_data;
                CFG_GEAR:       r_gear       <= i_cfg_data;
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // divider step compare
    assign n_qbit = r_rem >= r_dsh;

    // rounded magnitude, saturated
    always_comb begin
        if (r_czero) begin
            n_mag = '0;
        end else if (r_q[K]) begin
            n_mag = RPM_MAX;
        end else begin
            n_mag = RPM_BITS'(r_q[K-1:0]);
        end
    end

    // event counters, direction and held rpm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_elapsed <= '0;
            r_since   <= '0;
            r_held    <= '0;
            r_dir     <= 1'b1;
            r_updated <= 1'b0;
        end else if (i_cmd.accept) begin
            case (i_opcode)
                OP_TICK: begin
                    if (r_elapsed != '1) r_elapsed <= r_elapsed + 32'd1;
                    if (r_since != '1)   r_since   <= r_since + 32'd1;
                end
                OP_PULSE: begin
                    if (r_count != '1) r_count <= r_count + COUNT_BITS'(1);
                end
                OP_READ: begin
                    r_updated <= 1'b0;
                end
                OP_DIR: begin
                    r_dir <= i_forward;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.finish) begin
            r_held    <= r_dir ? n_mag : RPM_BITS'(0) - n_mag;
            r_count   <= '0;
            r_elapsed <= '0;
            r_since   <= '0;
            r_updated <= 1'b1;
        end
    end

    // products: numerator count*scale, denominator elapsed*cpr*gear
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_p1    <= 48'(r_elapsed) * 48'(r_cpr);
            r_num   <= N_W'(r_count) * N_W'(SCALE_LO)
                     + (N_W'(N_W'(r_count) * N_W'(SCALE_HI)) << 32);
            r_czero <= r_count == '0;
        end
        if (i_cmd.mul2) begin
            r_den <= 64'(r_p1) * 64'(r_gear);
        end
    end

    // divide (2*num + den) by 2*den, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_rem <= WIDE'({r_num, 1'b0}) + WIDE'(r_den);
            r_dsh <= WIDE'({r_den, 1'b0}) << K;
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            if (n_qbit) r_rem <= r_rem - r_dsh;
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[K-1:0], n_qbit};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_rpm     <= r_held;
            o_stale   <= r_since > (32'(r_timeout) * US_PER_MS);
            o_updated <= r_updated;
        end
    end

endmodule

`default_nettype wire

/* design/hprm_ctrl.sv */
// controller: event acceptance, product and divide sequencing, output handshake
`default_nettype none

module hprm_ctrl import hprm_pkg::*; #(
    parameter int RPM_BITS = 14
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    input  wire logic [1:0] i_opcode,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd     o_cmd
);

    localparam int K      = RPM_BITS - 1;
    localparam int STEP_W = $clog2(K + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic              n_in_xfer, n_load;

    assign o_in_ready  = r_state == S_IDLE;
    assign n_in_xfer   = i_in_valid && o_in_ready;
    assign n_load      = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = n_in_xfer;
        o_cmd.mul1     = r_state == S_MUL1;
        o_cmd.mul2     = r_state == S_MUL2;
        o_cmd.prep     = r_state == S_PREP;
        o_cmd.div_step = r_state == S_DIV;
        o_cmd.finish   = r_state == S_FIN;
        o_cmd.load_out = n_load;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (n_in_xfer && i_opcode == OP_READ) begin
                    n_state = i_sts.win_done ? S_MUL1 : S_OUT;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_PREP;
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (r_step == STEP_W'(K)) n_state = S_FIN;
            end
            S_FIN: n_state = S_OUT;
            S_OUT: begin
                if (n_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, divide step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PREP) begin
                r_step <= '0;
            end else if (r_state == S_DIV) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* design/hall_pulse_rpm_meter.sv */
// hall pulse rpm meter: top level
//
// Input channel (i_in_valid / o_in_ready) carries one event per transfer:
// a microsecond tick, a hall pulse, a direction change (i_forward) or a
// read request. Ticks, pulses and direction changes are applied on transfer.
// Every read yields exactly one result on the output channel (o_out_valid /
// i_out_ready): the held signed rpm, a stale flag and an updated flag.
// A read whose window is still short goes straight to the output state and
// loads the output register once the receiver has taken any earlier result.
// A read that closes the window runs the multiply states, a setup state, the
// divide state (one quotient bit per step through a shift-subtract unit), a
// finish state and the output state, during which no event is taken.
// The output register lets ticks keep flowing while a result waits; a
// second read waits in the output state until the receiver takes the first.
// Synchronous active-low reset restores the configuration defaults, clears
// counters and held rpm, sets direction to forward and empties the output.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) go straight to their registers.
`default_nettype none

module hall_pulse_rpm_meter import hprm_pkg::*; #(
    parameter int COUNT_BITS = 24,
    parameter int RPM_BITS   = 14
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [1:0]             i_opcode,
    input  wire logic                   i_forward,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic signed [RPM_BITS-1:0]  o_rpm,
    output logic                        o_stale,
    output logic                        o_updated,
    input  wire logic                   i_cfg_we,
    input  wire logic [1:0]             i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencing
    hprm_ctrl #(
        .RPM_BITS (RPM_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // counters and arithmetic
    hprm_dp #(
        .COUNT_BITS (COUNT_BITS),
        .RPM_BITS   (RPM_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_opcode   (i_opcode),
        .i_forward  (i_forward),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_rpm      (o_rpm),
        .o_stale    (o_stale),
        .o_updated  (o_updated)
    );

endmodule

`default_nettype wire

/* design/hprm_checker.sv */
// port-level checker for the hall pulse rpm meter and its bind
`default_nettype none

`include "hall_pulse_rpm_meter_assert.svh"

module hprm_checker import hprm_pkg::*; #(
    parameter int RPM_BITS = 14
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_ready,
    input wire logic [1:0]            i_opcode,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [RPM_BITS-1:0]   o_rpm,
    input wire logic                  o_stale,
    input wire logic                  o_updated
);

    localparam logic [RPM_BITS-1:0] RPM_MIN = {1'b1, {(RPM_BITS-1){1'b0}}};

    logic w_read_xfer, w_other_xfer;

    assign w_read_xfer  = i_in_valid && o_in_ready && i_opcode == OP_READ;
    assign w_other_xfer = i_in_valid && o_in_ready && i_opcode != OP_READ;

    // a stalled result holds
    `HPRM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_rpm) && $stable(o_stale) && $stable(o_updated))
    // a read transfer makes the block busy next cycle
    `HPRM_ASSERT_NEXT(a_busy_after_read, w_read_xfer, !o_in_ready)
    // only reads produce results
    `HPRM_ASSERT_NEXT(a_no_spurious, w_other_xfer && !o_out_valid, !o_out_valid)
    // a freshly computed rpm is never stale
    `HPRM_ASSERT_NOW(a_fresh_not_stale, o_out_valid && o_updated, !o_stale)
    // rpm stays inside the symmetric saturated range
    `HPRM_ASSERT_NOW(a_rpm_range, o_out_valid, o_rpm != RPM_MIN)

endmodule

bind hall_pulse_rpm_meter hprm_checker #(.RPM_BITS(RPM_BITS)) u_hprm_checker (.*);

`default_nettype wire
